[rtl/swrl_pkg.sv]
// Package for the sliding-window rate limiter: sizes, register indexes,
// request and response structs and the sequencer state type.
// Depends on nothing; used by the top level and the testbench.
package swrl_pkg;

    localparam int CLIENTS    = 64;
    localparam int RING_DEPTH = 256;
    localparam int TIME_BITS  = 48;

    localparam int SLOT_BITS  = 6;
    localparam int LIMIT_BITS = 9;
    localparam int WINDOW_BITS = 48;
    localparam int COUNT_OUT_BITS = 9;

    localparam int HEAD_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(RING_DEPTH + 1);
    localparam int SUM_BITS   = COUNT_BITS + 1;
    localparam int CMP_BITS   = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
    localparam int META_BITS  = HEAD_BITS + COUNT_BITS;
    localparam int TIME_DEPTH = CLIENTS * RING_DEPTH;
    localparam int TADDR_BITS = (TIME_DEPTH > 1) ? $clog2(TIME_DEPTH) : 1;
    localparam int MADDR_BITS = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] REG_REQUEST_LIMIT = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_TICKS  = 1'b1;

    localparam logic [LIMIT_BITS-1:0]  LIMIT_RESET  = 9'd200;
    localparam logic [WINDOW_BITS-1:0] WINDOW_RESET = 48'd900000;

    typedef struct packed {
        logic [SLOT_BITS-1:0] client_slot;
        logic [47:0]          now_tick;
    } req_t;

    typedef struct packed {
        logic                      allowed;
        logic [COUNT_OUT_BITS-1:0] in_window_count;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_META_RD,
        ST_LOAD,
        ST_TIME_RD,
        ST_TIME_CHK,
        ST_DECIDE
    } seq_state_t;

endpackage

[rtl/swrl_ram.sv]
// Generic single-port RAM with registered read data.
// Used for the admission time log and the per-client ring pointers.
// Depends on nothing.
module swrl_ram #(
    parameter int DATA_WIDTH = 8,
    parameter int DEPTH      = 16
) (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      addr,
    input  logic [DATA_WIDTH-1:0]         wdata,
    output logic [DATA_WIDTH-1:0]         rdata
);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sliding_window_rate_limiter_unit.sv]
// Top level of the sliding-window rate limiter: sequencer, configuration
// registers and the two RAMs. Depends on swrl_pkg and swrl_ram.
//
// Each request names a client slot and carries the current tick time. The
// client's log of admission times is trimmed from its oldest end of entries
// older than the window, then the request is admitted and logged if fewer
// than request_limit entries remain and the log is not full. Each log entry
// checked against the window, that is every expired entry and the first one
// kept, if any, is fetched from the single-port time RAM and checked by the
// one age comparator in turn. Only one request is in progress at a time;
// s_ready is high while the sequencer is idle, which it is again once each
// response is loaded, so a new request is not taken until the last one is
// through. The response register lets the next request in while a response
// waits, but a second response is held in the last step until the first has
// been taken.
module sliding_window_rate_limiter_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  swrl_pkg::req_t                        s_req,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output swrl_pkg::rsp_t                        m_rsp,
    input  logic                                  cfg_wr_en,
    input  logic [swrl_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [swrl_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data
);

    swrl_pkg::seq_state_t state_reg, state_next;

    logic [swrl_pkg::SLOT_BITS-1:0]   slot_reg;
    logic [swrl_pkg::TIME_BITS-1:0]   now_reg;
    logic [swrl_pkg::HEAD_BITS-1:0]   head_reg, head_next;
    logic [swrl_pkg::COUNT_BITS-1:0]  count_reg, count_next;
    logic [swrl_pkg::LIMIT_BITS-1:0]  limit_reg;
    logic [swrl_pkg::WINDOW_BITS-1:0] window_reg;
    logic [swrl_pkg::CLIENTS-1:0]     meta_valid_reg;
    logic                             m_valid_reg;
    swrl_pkg::rsp_t                   m_rsp_reg;

    logic                             meta_we;
    logic [swrl_pkg::MADDR_BITS-1:0]  meta_addr;
    logic [swrl_pkg::META_BITS-1:0]   meta_wdata;
    logic [swrl_pkg::META_BITS-1:0]   meta_rdata;
    logic                             time_we;
    logic [swrl_pkg::TADDR_BITS-1:0]  time_addr;
    logic [swrl_pkg::TIME_BITS-1:0]   time_rdata;

    logic                             accept;
    logic                             out_free;
    logic [swrl_pkg::HEAD_BITS-1:0]   load_head;
    logic [swrl_pkg::COUNT_BITS-1:0]  load_count;
    logic [swrl_pkg::TIME_BITS:0]     age_diff;
    logic                             expire;
    logic [swrl_pkg::HEAD_BITS-1:0]   head_inc;
    logic [swrl_pkg::SUM_BITS-1:0]    tail_sum;
    logic [swrl_pkg::HEAD_BITS-1:0]   tail;
    logic                             admit;
    logic [swrl_pkg::COUNT_BITS-1:0]  count_after;
    logic [swrl_pkg::TADDR_BITS-1:0]  time_base;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Pointer arithmetic and the age comparator.
    always_comb begin
        load_head  = '0;
        load_count = '0;
        if (meta_valid_reg[slot_reg]) begin
            load_head  = meta_rdata[swrl_pkg::META_BITS-1:swrl_pkg::COUNT_BITS];
            load_count = meta_rdata[swrl_pkg::COUNT_BITS-1:0];
        end

        age_diff = {1'b0, now_reg} - {1'b0, time_rdata};
        expire   = !age_diff[swrl_pkg::TIME_BITS] &&
                   ({{(swrl_pkg::WINDOW_BITS > swrl_pkg::TIME_BITS ?
                       swrl_pkg::WINDOW_BITS - swrl_pkg::TIME_BITS : 0){1'b0}},
                     age_diff[swrl_pkg::TIME_BITS-1:0]} >
                    {{(swrl_pkg::TIME_BITS > swrl_pkg::WINDOW_BITS ?
                       swrl_pkg::TIME_BITS - swrl_pkg::WINDOW_BITS : 0){1'b0}},
                     window_reg});

        if (head_reg == swrl_pkg::HEAD_BITS'(swrl_pkg::RING_DEPTH - 1)) begin
            head_inc = '0;
        end else begin
            head_inc = head_reg + swrl_pkg::HEAD_BITS'(1);
        end

        tail_sum = swrl_pkg::SUM_BITS'(head_reg) + swrl_pkg::SUM_BITS'(count_reg);
        if (tail_sum >= swrl_pkg::SUM_BITS'(swrl_pkg::RING_DEPTH)) begin
            tail_sum = tail_sum - swrl_pkg::SUM_BITS'(swrl_pkg::RING_DEPTH);
        end
        tail = tail_sum[swrl_pkg::HEAD_BITS-1:0];

        admit = (swrl_pkg::CMP_BITS'(count_reg) < swrl_pkg::CMP_BITS'(limit_reg)) &&
                (count_reg != swrl_pkg::COUNT_BITS'(swrl_pkg::RING_DEPTH));
        count_after = admit ? count_reg + swrl_pkg::COUNT_BITS'(1) : count_reg;

        time_base = swrl_pkg::TADDR_BITS'(slot_reg) *
                    swrl_pkg::TADDR_BITS'(swrl_pkg::RING_DEPTH);
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swrl_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = swrl_pkg::ST_META_RD;
                end
            end
            swrl_pkg::ST_META_RD: begin
                state_next = swrl_pkg::ST_LOAD;
            end
            swrl_pkg::ST_LOAD: begin
                state_next = (load_count == '0) ? swrl_pkg::ST_DECIDE : swrl_pkg::ST_TIME_RD;
            end
            swrl_pkg::ST_TIME_RD: begin
                state_next = swrl_pkg::ST_TIME_CHK;
            end
            swrl_pkg::ST_TIME_CHK: begin
                if (expire && count_reg != swrl_pkg::COUNT_BITS'(1)) begin
                    state_next = swrl_pkg::ST_TIME_RD;
                end else begin
                    state_next = swrl_pkg::ST_DECIDE;
                end
            end
            swrl_pkg::ST_DECIDE: begin
                if (out_free) begin
                    state_next = swrl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swrl_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs and pointer updates.
    always_comb begin
        s_ready    = 1'b0;
        meta_we    = 1'b0;
        time_we    = 1'b0;
        meta_addr  = swrl_pkg::MADDR_BITS'(slot_reg);
        meta_wdata = {head_reg, count_after};
        time_addr  = time_base + swrl_pkg::TADDR_BITS'(head_reg);
        head_next  = head_reg;
        count_next = count_reg;
        case (state_reg)
            swrl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            swrl_pkg::ST_LOAD: begin
                head_next  = load_head;
                count_next = load_count;
            end
            swrl_pkg::ST_TIME_CHK: begin
                if (expire) begin
                    head_next  = head_inc;
                    count_next = count_reg - swrl_pkg::COUNT_BITS'(1);
                end
            end
            swrl_pkg::ST_DECIDE: begin
                time_addr = time_base + swrl_pkg::TADDR_BITS'(tail);
                if (out_free) begin
                    meta_we    = 1'b1;
                    time_we    = admit;
                    count_next = count_after;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= swrl_pkg::ST_IDLE;
            meta_valid_reg <= '0;
            m_valid_reg    <= 1'b0;
            limit_reg      <= swrl_pkg::LIMIT_RESET;
            window_reg     <= swrl_pkg::WINDOW_RESET;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    swrl_pkg::REG_REQUEST_LIMIT: begin
                        limit_reg <= cfg_wr_data[swrl_pkg::LIMIT_BITS-1:0];
                    end
                    swrl_pkg::REG_WINDOW_TICKS: begin
                        window_reg <= cfg_wr_data[swrl_pkg::WINDOW_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (meta_we) begin
                meta_valid_reg[slot_reg] <= 1'b1;
            end
            if (state_reg == swrl_pkg::ST_DECIDE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            slot_reg <= s_req.client_slot;
            now_reg  <= swrl_pkg::TIME_BITS'(s_req.now_tick);
        end
        head_reg  <= head_next;
        count_reg <= count_next;
        if (state_reg == swrl_pkg::ST_DECIDE && out_free) begin
            m_rsp_reg.allowed         <= admit;
            m_rsp_reg.in_window_count <= swrl_pkg::COUNT_OUT_BITS'(count_after);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    swrl_ram #(
        .DATA_WIDTH (swrl_pkg::META_BITS),
        .DEPTH      (swrl_pkg::CLIENTS)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .addr  (meta_addr),
        .wdata (meta_wdata),
        .rdata (meta_rdata)
    );

    swrl_ram #(
        .DATA_WIDTH (swrl_pkg::TIME_BITS),
        .DEPTH      (swrl_pkg::TIME_DEPTH)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (time_we),
        .addr  (time_addr),
        .wdata (now_reg),
        .rdata (time_rdata)
    );

endmodule

[dv/tb_sliding_window_rate_limiter_unit.sv]
// Testbench for sliding_window_rate_limiter_unit: a directed table and random phases,
// with every response checked against a typed verdict or a predictor of the admission logs.
// Depends on swrl_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_sliding_window_rate_limiter_unit;

    import swrl_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1_500_000;
    localparam int unsigned IDLE_PERCENT = 21;
    localparam logic [47:0] TICK_MAX     = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ROW_REQUEST,
        ROW_SET_LIMIT,
        ROW_SET_WINDOW
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [SLOT_BITS-1:0] client_slot;
        logic [47:0]          value;
        logic                 checked;
        rsp_t                 verdict;
    } script_row_t;

    typedef struct {
        logic [LIMIT_BITS-1:0]  limit;
        logic [WINDOW_BITS-1:0] window;
        int unsigned            requests;
        int unsigned            slot_lo;
        int unsigned            slot_hi;
        int unsigned            max_step;
        bit                     no_idle;
    } traffic_phase_t;

    localparam int SCRIPT_ROWS = 25;
    localparam int PHASES      = 7;

    // Expected responses are typed in where they follow from the rows before them at a glance.
    script_row_t directed_script [SCRIPT_ROWS] = '{
        '{ROW_REQUEST,    6'd0,  48'd0,              1'b1, '{1'b1, 9'd1}},
        '{ROW_REQUEST,    6'd63, TICK_MAX,           1'b1, '{1'b1, 9'd1}},
        '{ROW_REQUEST,    6'd0,  48'd900000,         1'b1, '{1'b1, 9'd2}},
        '{ROW_REQUEST,    6'd0,  48'd900001,         1'b1, '{1'b1, 9'd2}},
        '{ROW_REQUEST,    6'd63, 48'd0,              1'b1, '{1'b1, 9'd2}},
        '{ROW_REQUEST,    6'd63, 48'd5,              1'b1, '{1'b1, 9'd3}},
        '{ROW_SET_LIMIT,  6'd0,  48'd0,              1'b0, '{1'b0, 9'd0}},
        '{ROW_REQUEST,    6'd0,  48'd900001,         1'b1, '{1'b0, 9'd2}},
        '{ROW_REQUEST,    6'd0,  48'd2000000,        1'b1, '{1'b0, 9'd0}},
        '{ROW_SET_LIMIT,  6'd0,  48'd256,            1'b0, '{1'b0, 9'd0}},
        '{ROW_SET_WINDOW, 6'd0,  48'd0,              1'b0, '{1'b0, 9'd0}},
        '{ROW_REQUEST,    6'd1,  48'd5,              1'b1, '{1'b1, 9'd1}},
        '{ROW_REQUEST,    6'd1,  48'd5,              1'b1, '{1'b1, 9'd2}},
        '{ROW_REQUEST,    6'd1,  48'd6,              1'b1, '{1'b1, 9'd1}},
        '{ROW_SET_LIMIT,  6'd0,  48'd2,              1'b0, '{1'b0, 9'd0}},
        '{ROW_SET_WINDOW, 6'd0,  TICK_MAX,           1'b0, '{1'b0, 9'd0}},
        '{ROW_REQUEST,    6'd42, 48'd100,            1'b1, '{1'b1, 9'd1}},
        '{ROW_REQUEST,    6'd42, 48'd200,            1'b1, '{1'b1, 9'd2}},
        '{ROW_REQUEST,    6'd42, 48'd300,            1'b1, '{1'b0, 9'd2}},
        '{ROW_SET_LIMIT,  6'd0,  48'd511,            1'b0, '{1'b0, 9'd0}},
        '{ROW_REQUEST,    6'd42, 48'd300,            1'b1, '{1'b1, 9'd3}},
        '{ROW_SET_WINDOW, 6'd0,  48'd1,              1'b0, '{1'b0, 9'd0}},
        '{ROW_REQUEST,    6'd21, 48'h5555_5555_5555, 1'b0, '{1'b0, 9'd0}},
        '{ROW_REQUEST,    6'd42, 48'd301,            1'b1, '{1'b1, 9'd2}},
        '{ROW_REQUEST,    6'd21, 48'hAAAA_AAAA_AAAA, 1'b0, '{1'b0, 9'd0}}
    };

    // The first phase fills one client's log to the ring depth; the second expires it at once.
    traffic_phase_t traffic_phases [PHASES] = '{
        '{9'd511, TICK_MAX,       280, 5, 5,  3,     1'b0},
        '{9'd256, 48'd0,          20,  5, 5,  2,     1'b0},
        '{9'd3,   48'd40,         80,  0, 7,  15,    1'b1},
        '{9'd0,   48'd1000,       20,  0, 63, 50,    1'b0},
        '{9'd1,   48'd1,          60,  0, 3,  2,     1'b0},
        '{9'd200, 48'd900000,     30,  0, 63, 30000, 1'b0},
        '{9'd256, 48'd500,        40,  8, 9,  3,     1'b0}
    };

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      s_valid     = 1'b0;
    logic                      s_ready;
    req_t                      s_req       = '0;
    logic                      m_valid;
    logic                      m_ready     = 1'b0;
    rsp_t                      m_rsp;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data = '0;

    logic [TIME_BITS-1:0]   admission_log [CLIENTS][RING_DEPTH];
    int unsigned            log_head [CLIENTS];
    int unsigned            log_fill [CLIENTS];
    logic [LIMIT_BITS-1:0]  admit_limit = LIMIT_RESET;
    logic [WINDOW_BITS-1:0] window_len  = WINDOW_RESET;

    rsp_t        pending_verdicts [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    bit          no_idle     = 1'b0;

    always #2 aclk = ~aclk;

    sliding_window_rate_limiter_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_req       (s_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rsp       (m_rsp),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    function automatic rsp_t admit_request(req_t r);
        int unsigned      slot;
        int unsigned      head;
        int unsigned      fill;
        logic [47:0]      age;
        logic [47:0]      oldest;
        bit               granted;
        rsp_t             verdict;
        slot = r.client_slot;
        if (slot >= CLIENTS) begin
            return '0;
        end
        head = log_head[slot];
        fill = log_fill[slot];
        while (fill > 0) begin
            oldest = admission_log[slot][head];
            age = (r.now_tick >= oldest) ? r.now_tick - oldest : '0;
            if (age <= window_len) begin
                break;
            end
            head = (head + 1) % RING_DEPTH;
            fill--;
        end
        granted = (fill < admit_limit) && (fill < RING_DEPTH);
        if (granted) begin
            admission_log[slot][(head + fill) % RING_DEPTH] = r.now_tick;
            fill++;
        end
        log_head[slot] = head;
        log_fill[slot] = fill;
        verdict.allowed = granted;
        verdict.in_window_count = COUNT_OUT_BITS'(fill);
        return verdict;
    endfunction

    task automatic push_request(input req_t r, input bit checked, input rsp_t typed_verdict);
        rsp_t predicted;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req   <= r;
        do @(posedge aclk); while (!s_ready);
        predicted = admit_request(r);
        pending_verdicts = {pending_verdicts, (checked ? typed_verdict : predicted)};
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (pending_verdicts.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] data);
        s_valid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        if (idx == REG_REQUEST_LIMIT) begin
            admit_limit = data[LIMIT_BITS-1:0];
        end else begin
            window_len = data[WINDOW_BITS-1:0];
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    always @(posedge aclk) begin : response_check
        rsp_t expected;
        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                $error("response arrived with no request outstanding");
                fail_count++;
            end else begin
                expected = pending_verdicts.pop_front();
                if (m_rsp.allowed !== expected.allowed) begin
                    $error("allowed: expected %0d, actual %0d", expected.allowed, m_rsp.allowed);
                    fail_count++;
                end
                if (m_rsp.in_window_count !== expected.in_window_count) begin
                    $error("in_window_count: expected %0d, actual %0d",
                           expected.in_window_count, m_rsp.in_window_count);
                    fail_count++;
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        req_t        r;
        logic [47:0] tick_now;
        int unsigned slot_pick;
        foreach (log_head[c]) begin
            log_head[c] = 0;
            log_fill[c] = 0;
        end
        tick_now = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_script[i]) begin
            case (directed_script[i].kind)
                ROW_SET_LIMIT: begin
                    write_register(REG_REQUEST_LIMIT, directed_script[i].value);
                end
                ROW_SET_WINDOW: begin
                    write_register(REG_WINDOW_TICKS, directed_script[i].value);
                end
                default: begin
                    r.client_slot = directed_script[i].client_slot;
                    r.now_tick    = directed_script[i].value;
                    push_request(r, directed_script[i].checked, directed_script[i].verdict);
                end
            endcase
        end

        foreach (traffic_phases[p]) begin
            write_register(REG_REQUEST_LIMIT, CFG_DATA_BITS'(traffic_phases[p].limit));
            write_register(REG_WINDOW_TICKS, traffic_phases[p].window);
            no_idle = traffic_phases[p].no_idle;
            repeat (traffic_phases[p].requests) begin
                if ($urandom_range(0, 15) == 0) begin
                    slot_pick = $urandom_range(0, CLIENTS - 1);
                end else begin
                    slot_pick = $urandom_range(traffic_phases[p].slot_lo,
                                               traffic_phases[p].slot_hi);
                end
                // Now and then the clock jumps to an arbitrary value, backwards as often as not.
                if ($urandom_range(0, 39) == 0) begin
                    tick_now = {16'($urandom), 32'($urandom)};
                end else begin
                    tick_now = tick_now + $urandom_range(0, traffic_phases[p].max_step);
                end
                r.client_slot = SLOT_BITS'(slot_pick);
                r.now_tick    = tick_now;
                push_request(r, 1'b0, '0);
            end
            no_idle = 1'b0;
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_verdicts.size() != 0);
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/swrl_pkg.sv
rtl/swrl_ram.sv
rtl/sliding_window_rate_limiter_unit.sv
dv/tb_sliding_window_rate_limiter_unit.sv
